/* rtl/twl_pkg.sv */
`timescale 1ns / 1ps

package twl_pkg;

    // Default list geometry
    localparam int TWL_DEPTH     = 16;
    localparam int TWL_TIME_BITS = 16;

    // One sweep releases at most this many entries
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_SWEEP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  waiter_id;
        logic [15:0] wait_ticks;
    } t_in_word;

    typedef struct packed {
        logic [7:0] released_id;
        logic       id_valid;
        logic       last_of_run;
        logic [6:0] released_count;
        logic [1:0] status;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic tick;
        logic remove;
        logic sweep_start;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_func func;
        logic  out_free;
        logic  rem_zero;
        logic  head_release;
        logic  pend_valid;
    } t_dp_sts;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

/* rtl/twl_ctrl.sv */
`timescale 1ns / 1ps

module twl_ctrl import twl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.func)
                    FUNC_INSERT: begin
                        if (i_sts.out_free) begin
                            o_cmd.insert = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    FUNC_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_IDLE;
                    end
                    FUNC_REMOVE: begin
                        if (i_sts.out_free) begin
                            o_cmd.remove = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    FUNC_SWEEP: begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = S_SCAN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                // a release with a held result pushes that result out first
                if (i_sts.rem_zero) begin
                    n_state = S_DONE;
                end else if (!(i_sts.head_release && i_sts.pend_valid) || i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/twl_dp.sv */
`timescale 1ns / 1ps

module twl_dp import twl_pkg::*; #(
    parameter int DEPTH     = TWL_DEPTH,
    parameter int TIME_BITS = TWL_TIME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [31:0] TMAX = 32'((64'd1 << TIME_BITS) - 64'd1);

    // latched input word
    t_func       r_func;
    logic [7:0]  r_id;
    logic [15:0] r_ticks;

    // entry shift line, oldest at index 0
    logic [7:0]           r_hdl   [DEPTH];
    logic [TIME_BITS-1:0] r_cnt   [DEPTH];
    logic                 r_timed [DEPTH];

    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] r_rem;
    logic [CNT_W-1:0] r_nrel;
    logic             r_pend_valid;
    logic [7:0]       r_pend_id;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             full;
    logic             empty;
    logic             out_free;
    logic             head_release;
    logic             wrap;
    logic [31:0]      ticks_wide;
    logic [TIME_BITS-1:0] ticks_sat;
    logic [OCC_W-1:0] occ_m1;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] keep_idx;
    logic             push;
    t_out_word        n_out_word;

    assign full         = (r_occ == OCC_W'(DEPTH));
    assign empty        = (r_occ == '0);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign head_release = r_timed[0] && (r_cnt[0] == '0) && (r_nrel < CNT_W'(MAX_RESULTS));
    assign wrap         = i_cmd.step && !head_release;
    assign ticks_wide   = {16'd0, r_ticks};
    assign ticks_sat    = (ticks_wide > TMAX) ? TMAX[TIME_BITS-1:0]
                                              : ticks_wide[TIME_BITS-1:0];
    assign occ_m1       = r_occ - OCC_W'(1);
    assign ins_idx      = r_occ[IDX_W-1:0];
    assign keep_idx     = occ_m1[IDX_W-1:0];

    assign o_sts.func         = r_func;
    assign o_sts.out_free     = out_free;
    assign o_sts.rem_zero     = (r_rem == '0);
    assign o_sts.head_release = head_release;
    assign o_sts.pend_valid   = r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_in_word.func);
            r_id    <= i_in_word.waiter_id;
            r_ticks <= i_in_word.wait_ticks;
        end
    end

    // entry storage: append at tail, decrement all, shift toward head
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !full) begin
            r_hdl[ins_idx]   <= r_id;
            r_cnt[ins_idx]   <= ticks_sat;
            r_timed[ins_idx] <= (ticks_sat != '0);
        end
        if (i_cmd.tick) begin
            for (int k = 0; k < DEPTH; k++) begin
                if (r_cnt[k] != '0) begin
                    r_cnt[k] <= r_cnt[k] - TIME_BITS'(1);
                end
            end
        end
        if ((i_cmd.remove && !empty) || i_cmd.step) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                if (!(wrap && (IDX_W'(k) == keep_idx))) begin
                    r_hdl[k]   <= r_hdl[k+1];
                    r_cnt[k]   <= r_cnt[k+1];
                    r_timed[k] <= r_timed[k+1];
                end
            end
            // a kept head wraps around to the tail of the list
            if (wrap) begin
                r_hdl[keep_idx]   <= r_hdl[0];
                r_cnt[keep_idx]   <= r_cnt[0];
                r_timed[keep_idx] <= r_timed[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if ((i_cmd.insert && !full)) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if ((i_cmd.remove && !empty) || (i_cmd.step && head_release)) begin
                r_occ <= occ_m1;
            end
            if (i_cmd.sweep_start || i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && head_release) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_rem  <= r_occ;
            r_nrel <= '0;
        end else if (i_cmd.step) begin
            r_rem <= r_rem - OCC_W'(1);
            if (head_release) begin
                r_nrel    <= r_nrel + CNT_W'(1);
                r_pend_id <= r_hdl[0];
            end
        end
    end

    always_comb begin
        push       = 1'b0;
        n_out_word = '0;
        n_out_word.last_of_run = 1'b1;
        n_out_word.status      = ST_OK;
        if (i_cmd.insert) begin
            push = 1'b1;
            n_out_word.status = full ? ST_FULL : ST_OK;
        end else if (i_cmd.remove) begin
            push = 1'b1;
            if (empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_out_word.released_id = r_hdl[0];
                n_out_word.id_valid    = 1'b1;
            end
        end else if (i_cmd.step && head_release && r_pend_valid) begin
            push = 1'b1;
            n_out_word.released_id = r_pend_id;
            n_out_word.id_valid    = 1'b1;
            n_out_word.last_of_run = 1'b0;
        end else if (i_cmd.finish) begin
            push = 1'b1;
            if (r_pend_valid) begin
                n_out_word.released_id    = r_pend_id;
                n_out_word.id_valid       = 1'b1;
                n_out_word.released_count = 7'(r_nrel);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= push || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* rtl/timed_wait_list_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_word  (t_in_word)
// out       output     o_out_valid / i_out_stall o_out_word (t_out_word)
//
// Insert, tick and remove latch the word, then act; insert and remove also wait
// for a free output register. A sweep latches, starts, pops each entry from the
// head of the shift line (release it or re-append it), makes a closing check, and
// pushes the final result. Output back-pressure stalls the sequence only where a
// result must be pushed.
// Reset (i_rst_n low, synchronous) empties the list; entry storage is not cleared.
// A new word is taken while the last result still waits in the output register.

module timed_wait_list_core import twl_pkg::*; #(
    parameter int DEPTH     = TWL_DEPTH,
    parameter int TIME_BITS = TWL_TIME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence the operation: latch, act, and for a sweep scan then close
    twl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold the entries, counters and output register
    twl_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // An invalid result always closes its run
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.id_valid |-> o_out_word.last_of_run)
        else $error("invalid result not marked last");

    // A nonzero release count appears only on the last, valid result of a sweep
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.released_count != 7'd0)
        |-> o_out_word.last_of_run && o_out_word.id_valid
            && (o_out_word.status == ST_OK))
        else $error("release count on a non-final result");

    // Error status never carries a handle
    a_err_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK)
        |-> !o_out_word.id_valid && o_out_word.last_of_run)
        else $error("error status with a valid handle");

    // The scan never steps while a released result is blocked
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step && sts.head_release && sts.pend_valid |-> sts.out_free)
        else $error("sweep advanced over a blocked output");

endmodule
